@@ design/hmq_pkg.sv @@
package hmq_pkg;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [39:0] ROUND_HALF = 40'h0000800000;

    localparam logic [8:0]  GRID_WIDTH_RESET        = 9'd256;
    localparam logic [8:0]  GRID_DEPTH_RESET        = 9'd256;
    localparam logic [15:0] INVERSE_CELL_SIZE_RESET = 16'd256;
    localparam logic [15:0] HEIGHT_GAIN_RESET       = 16'd6554;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH,
        REG_GRID_DEPTH,
        REG_INVERSE_CELL_SIZE,
        REG_HEIGHT_GAIN
    } cfg_reg_t;

    typedef struct packed {
        logic               mode;
        logic [15:0]        sample_index;
        logic [7:0]         sample_value;
        logic signed [15:0] query_x;
        logic signed [15:0] query_z;
    } item_t;

    typedef struct packed {
        logic [15:0] terrain_height;
        logic        inside_grid;
    } result_t;

endpackage

@@ design/hmq_ram.sv @@
module hmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/heightmap_height_query_top.sv @@
// Each query's result is registered through every stage; loads give no result.
// Throughput: one transaction (load or query) per cycle unless result_stall holds it up.
// The rate is set by four copies of the height store, each with its own read port,
// so all corner samples of a cell are read in the same cycle.
// Reset clears pipeline valids and sets the registers to 256, 256, 256, 6554;
// the height store is not cleared and holds undefined values until loaded.
module heightmap_height_query_top #(
    parameter int MAX_GRID_WIDTH = 256,
    parameter int MAX_GRID_DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  hmq_pkg::item_t                        item,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output hmq_pkg::result_t                      result,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [hmq_pkg::PADDR_W-1:0]           paddr,
    input  logic [hmq_pkg::PDATA_W-1:0]           pwdata,
    output logic [hmq_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready
);

    import hmq_pkg::*;

    localparam int STORE_SIZE = MAX_GRID_WIDTH * MAX_GRID_DEPTH;
    localparam int AW         = $clog2(STORE_SIZE);
    localparam int WW         = $clog2(MAX_GRID_WIDTH + 1);
    localparam int DW         = $clog2(MAX_GRID_DEPTH + 1);
    localparam int CXW        = $clog2(MAX_GRID_WIDTH);
    localparam int CZW        = $clog2(MAX_GRID_DEPTH);
    localparam int NUM_PORTS  = 4;
    localparam int H00        = 0;
    localparam int H10        = 1;
    localparam int H01        = 2;
    localparam int H11        = 3;

    // configuration registers
    logic [8:0]  grid_width_reg;
    logic [8:0]  grid_depth_reg;
    logic [15:0] inverse_cell_size_reg;
    logic [15:0] height_gain_reg;
    logic        cfg_write;
    logic [WW-1:0] w_eff;
    logic [DW-1:0] d_eff;

    // flow control
    logic free_out;
    logic free1, free2, free3, free4, free5, free6;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic result_valid_reg;
    result_t result_reg;
    result_t result_next;

    // stage 1
    logic               s1_mode_reg;
    logic [15:0]        s1_idx_reg;
    logic [7:0]         s1_val_reg;
    logic signed [31:0] s1_gx_reg;
    logic signed [31:0] s1_gz_reg;
    logic signed [31:0] gx_next;
    logic signed [31:0] gz_next;
    logic signed [31:0] inv_ext;

    // stage 2
    logic               s2_mode_reg;
    logic [15:0]        s2_idx_reg;
    logic [7:0]         s2_val_reg;
    logic               s2_inside_reg;
    logic [AW-1:0]      s2_base_reg;
    logic [CXW-1:0]     s2_cx_reg;
    logic [15:0]        s2_fx_reg;
    logic [15:0]        s2_fz_reg;
    logic [15:0]        cell_x;
    logic [15:0]        cell_z;
    logic [CZW-1:0]     cz;
    logic               inside_next;
    logic [AW-1:0]      base_next;

    // stage 3
    logic               s3_inside_reg;
    logic [15:0]        s3_fx_reg;
    logic [15:0]        s3_fz_reg;
    logic [AW-1:0]      rd_addr [NUM_PORTS];
    logic [7:0]         rd_data [NUM_PORTS];
    logic               rd_en;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               upper;
    logic [7:0]         base_next_s;
    logic [16:0]        wa;
    logic [16:0]        wb;
    logic signed [8:0]  da;
    logic signed [8:0]  db;
    logic signed [26:0] p1_next;
    logic signed [26:0] p2_next;

    // stage 4
    logic               s4_inside_reg;
    logic [7:0]         s4_base_reg;
    logic signed [26:0] s4_p1_reg;
    logic signed [26:0] s4_p2_reg;
    logic signed [27:0] sum_next;
    logic [23:0]        hq_next;

    // stage 5
    logic               s5_inside_reg;
    logic [23:0]        s5_hq_reg;
    logic [39:0]        prod_next;

    // stage 6
    logic               s6_inside_reg;
    logic [39:0]        s6_prod_reg;
    logic [39:0]        rounded;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg        <= GRID_WIDTH_RESET;
            grid_depth_reg        <= GRID_DEPTH_RESET;
            inverse_cell_size_reg <= INVERSE_CELL_SIZE_RESET;
            height_gain_reg       <= HEIGHT_GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(paddr[3:2]))
                REG_GRID_WIDTH:        grid_width_reg        <= pwdata[8:0];
                REG_GRID_DEPTH:        grid_depth_reg        <= pwdata[8:0];
                REG_INVERSE_CELL_SIZE: inverse_cell_size_reg <= pwdata[15:0];
                REG_HEIGHT_GAIN:       height_gain_reg       <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_reg_t'(paddr[3:2]))
            REG_GRID_WIDTH:        prdata = PDATA_W'(grid_width_reg);
            REG_GRID_DEPTH:        prdata = PDATA_W'(grid_depth_reg);
            REG_INVERSE_CELL_SIZE: prdata = PDATA_W'(inverse_cell_size_reg);
            REG_HEIGHT_GAIN:       prdata = PDATA_W'(height_gain_reg);
        endcase
    end

    // saturate grid size to the store dimensions
    always_comb
    begin
        if (32'(grid_width_reg) > MAX_GRID_WIDTH)
        begin
            w_eff = WW'(MAX_GRID_WIDTH);
        end
        else
        begin
            w_eff = WW'(grid_width_reg);
        end
        if (32'(grid_depth_reg) > MAX_GRID_DEPTH)
        begin
            d_eff = DW'(MAX_GRID_DEPTH);
        end
        else
        begin
            d_eff = DW'(grid_depth_reg);
        end
    end

    // advance a stage whenever the one after it is empty or advancing
    assign free_out   = !result_valid_reg || !result_stall;
    assign free6      = !v6_reg || free_out;
    assign free5      = !v5_reg || free6;
    assign free4      = !v4_reg || free5;
    assign free3      = !v3_reg || free4;
    assign free2      = !v2_reg || free3;
    assign free1      = !v1_reg || free2;
    assign item_stall = !free1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            v6_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                v1_reg <= item_valid;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg && (s2_mode_reg == MODE_QUERY);
            end
            if (free4)
            begin
                v4_reg <= v3_reg;
            end
            if (free5)
            begin
                v5_reg <= v4_reg;
            end
            if (free6)
            begin
                v6_reg <= v5_reg;
            end
            if (free_out)
            begin
                result_valid_reg <= v6_reg;
            end
        end
    end

    // stage 1: scale position to grid units
    assign inv_ext = signed'(32'(inverse_cell_size_reg));
    assign gx_next = 32'(item.query_x) * inv_ext;
    assign gz_next = 32'(item.query_z) * inv_ext;

    always_ff @(posedge clk)
    begin
        if (free1)
        begin
            s1_mode_reg <= item.mode;
            s1_idx_reg  <= item.sample_index;
            s1_val_reg  <= item.sample_value;
            s1_gx_reg   <= gx_next;
            s1_gz_reg   <= gz_next;
        end
    end

    // stage 2: cell select, bounds check, row offset
    assign cell_x = s1_gx_reg[31:16];
    assign cell_z = s1_gz_reg[31:16];
    assign cz     = CZW'(cell_z);

    always_comb
    begin
        inside_next = 1'b1;
        if ((w_eff < WW'(2)) || (d_eff < DW'(2)) || s1_gx_reg[31] || s1_gz_reg[31])
        begin
            inside_next = 1'b0;
        end
        if (({1'b0, cell_x} >= (17'(w_eff) - 17'd1))
            || ({1'b0, cell_z} >= (17'(d_eff) - 17'd1)))
        begin
            inside_next = 1'b0;
        end
    end

    assign base_next = AW'(cz) * AW'(w_eff);

    always_ff @(posedge clk)
    begin
        if (free2)
        begin
            s2_mode_reg   <= s1_mode_reg;
            s2_idx_reg    <= s1_idx_reg;
            s2_val_reg    <= s1_val_reg;
            s2_inside_reg <= inside_next;
            s2_base_reg   <= base_next;
            s2_cx_reg     <= CXW'(cell_x);
            s2_fx_reg     <= s1_gx_reg[15:0];
            s2_fz_reg     <= s1_gz_reg[15:0];
        end
    end

    // stage 3: store access; loads and query reads happen at the same point, in order
    assign rd_addr[H00] = s2_base_reg + AW'(s2_cx_reg);
    assign rd_addr[H10] = rd_addr[H00] + AW'(1);
    assign rd_addr[H01] = rd_addr[H00] + AW'(w_eff);
    assign rd_addr[H11] = rd_addr[H01] + AW'(1);

    assign rd_en   = free3 && v2_reg && (s2_mode_reg == MODE_QUERY);
    assign wr_en   = free3 && v2_reg && (s2_mode_reg == MODE_LOAD)
                     && (32'(s2_idx_reg) < STORE_SIZE);
    assign wr_addr = AW'(s2_idx_reg);

    for (genvar i = 0; i < NUM_PORTS; i++)
    begin : g_bank
        hmq_ram #(
            .WIDTH (8),
            .DEPTH (STORE_SIZE)
        ) u_ram (
            .clk   (clk),
            .we    (wr_en),
            .waddr (wr_addr),
            .wdata (s2_val_reg),
            .re    (rd_en),
            .raddr (rd_addr[i]),
            .rdata (rd_data[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (free3)
        begin
            s3_inside_reg <= s2_inside_reg;
            s3_fx_reg     <= s2_fx_reg;
            s3_fz_reg     <= s2_fz_reg;
        end
    end

    // pick the triangle and form the two weighted differences
    assign upper = (17'(s3_fx_reg) + 17'(s3_fz_reg)) >= ONE_Q16;

    always_comb
    begin
        if (upper)
        begin
            base_next_s = rd_data[H11];
            wa          = ONE_Q16 - 17'(s3_fx_reg);
            wb          = ONE_Q16 - 17'(s3_fz_reg);
            da          = $signed({1'b0, rd_data[H01]}) - $signed({1'b0, rd_data[H11]});
            db          = $signed({1'b0, rd_data[H10]}) - $signed({1'b0, rd_data[H11]});
        end
        else
        begin
            base_next_s = rd_data[H00];
            wa          = 17'(s3_fx_reg);
            wb          = 17'(s3_fz_reg);
            da          = $signed({1'b0, rd_data[H10]}) - $signed({1'b0, rd_data[H00]});
            db          = $signed({1'b0, rd_data[H01]}) - $signed({1'b0, rd_data[H00]});
        end
    end

    assign p1_next = $signed({10'b0, wa}) * 27'(da);
    assign p2_next = $signed({10'b0, wb}) * 27'(db);

    always_ff @(posedge clk)
    begin
        if (free4)
        begin
            s4_inside_reg <= s3_inside_reg;
            s4_base_reg   <= base_next_s;
            s4_p1_reg     <= p1_next;
            s4_p2_reg     <= p2_next;
        end
    end

    // stage 5: sum and clamp at zero
    assign sum_next = $signed({4'b0, s4_base_reg, 16'b0}) + 28'(s4_p1_reg) + 28'(s4_p2_reg);
    assign hq_next  = sum_next[27] ? 24'd0 : sum_next[23:0];

    always_ff @(posedge clk)
    begin
        if (free5)
        begin
            s5_inside_reg <= s4_inside_reg;
            s5_hq_reg     <= hq_next;
        end
    end

    // stage 6: apply gain
    assign prod_next = 40'(s5_hq_reg) * 40'(height_gain_reg);

    always_ff @(posedge clk)
    begin
        if (free6)
        begin
            s6_inside_reg <= s5_inside_reg;
            s6_prod_reg   <= prod_next;
        end
    end

    // round half up to Q8.8, zero outside the grid
    assign rounded = s6_prod_reg + ROUND_HALF;

    always_comb
    begin
        result_next.inside_grid    = s6_inside_reg;
        result_next.terrain_height = s6_inside_reg ? rounded[39:24] : 16'd0;
    end

    always_ff @(posedge clk)
    begin
        if (free_out)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ design/hmq_checker.sv @@
module hmq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_stall,
    input hmq_pkg::item_t              item,
    input logic                        result_valid,
    input logic                        result_stall,
    input hmq_pkg::result_t            result,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [hmq_pkg::PADDR_W-1:0] paddr,
    input logic [hmq_pkg::PDATA_W-1:0] pwdata,
    input logic [hmq_pkg::PDATA_W-1:0] prdata,
    input logic                        pready
);

    import hmq_pkg::*;

    logic narrow_reg_addr;

    assign narrow_reg_addr = (paddr[3:2] == REG_GRID_WIDTH) || (paddr[3:2] == REG_GRID_DEPTH);

    // hold a stalled input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("input changed while stalled");

    // hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // drop height outside the grid
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.inside_grid |-> result.terrain_height == 16'd0)
        else $error("nonzero height outside grid");

    // accept whenever the output register can move
    assert property (@(posedge clk) disable iff (!rst_n)
        (!result_valid || !result_stall) |-> !item_stall)
        else $error("input stalled with output free");

    // read back the last register write
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready) ##1 (paddr == $past(paddr))
        |-> prdata == ($past(pwdata) & (narrow_reg_addr ? 32'h1FF : 32'hFFFF)))
        else $error("register readback mismatch");

endmodule

bind heightmap_height_query_top hmq_checker u_hmq_checker (.*);

@@ tb/sv/heightmap_height_query_top_tb.sv @@
module heightmap_height_query_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hmq_pkg::*;

    localparam int     MAX_GRID_WIDTH = 256;
    localparam int     MAX_GRID_DEPTH = 256;
    localparam longint UNIT_Q16       = 65536;
    localparam int     FLUSH_CYCLES   = 12;
    localparam int     CYCLE_LIMIT    = 400000;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    item_t               item;
    logic                result_valid;
    logic                result_stall;
    result_t             result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic [8:0]  cfg_width = GRID_WIDTH_RESET;
    logic [8:0]  cfg_depth = GRID_DEPTH_RESET;
    logic [15:0] cfg_ics   = INVERSE_CELL_SIZE_RESET;
    logic [15:0] cfg_gain  = HEIGHT_GAIN_RESET;

    logic [7:0]  height_mirror [0:65535];
    bit          sample_written [0:65535];
    result_t     height_expected [$];

    int          err_count   = 0;
    int          cycle_count = 0;
    bit          tx_idle_en  = 1'b1;
    bit          rx_idle_en  = 1'b1;
    logic        hold_off;
    int          hold_len    = 0;
    event        hold_go;

    heightmap_height_query_top #(
        .MAX_GRID_WIDTH (MAX_GRID_WIDTH),
        .MAX_GRID_DEPTH (MAX_GRID_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int eff_size(logic [8:0] v, int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic bit locate_cell(input logic signed [15:0] qx,
                                       input logic signed [15:0] qz,
                                       output int cx, output int cz,
                                       output longint fx, output longint fz);
        longint gx;
        longint gz;
        int     w;
        int     d;
        w  = eff_size(cfg_width, MAX_GRID_WIDTH);
        d  = eff_size(cfg_depth, MAX_GRID_DEPTH);
        gx = longint'(qx) * longint'(cfg_ics);
        gz = longint'(qz) * longint'(cfg_ics);
        cx = 0;
        cz = 0;
        fx = 0;
        fz = 0;
        if (w < 2 || d < 2 || gx < 0 || gz < 0)
            return 1'b0;
        if ((gx >> 16) >= longint'(w - 1) || (gz >> 16) >= longint'(d - 1))
            return 1'b0;
        cx = int'(gx >> 16);
        cz = int'(gz >> 16);
        fx = gx & 64'hFFFF;
        fz = gz & 64'hFFFF;
        return 1'b1;
    endfunction

    function automatic result_t predict_height(logic signed [15:0] qx,
                                               logic signed [15:0] qz);
        result_t r;
        int      cx;
        int      cz;
        int      w;
        int      base;
        longint  fx;
        longint  fz;
        longint  h00;
        longint  h10;
        longint  h01;
        longint  h11;
        longint  hq;
        longint  prod;
        r = '0;
        if (locate_cell(qx, qz, cx, cz, fx, fz))
        begin
            w    = eff_size(cfg_width, MAX_GRID_WIDTH);
            base = cx + cz * w;
            h00  = longint'(height_mirror[base]);
            h10  = longint'(height_mirror[base + 1]);
            h01  = longint'(height_mirror[base + w]);
            h11  = longint'(height_mirror[base + w + 1]);
            if (fx + fz < UNIT_Q16)
                hq = h00 * UNIT_Q16 + fx * (h10 - h00) + fz * (h01 - h00);
            else
                hq = h11 * UNIT_Q16 + (UNIT_Q16 - fx) * (h01 - h11)
                   + (UNIT_Q16 - fz) * (h10 - h11);
            if (hq < 0)
                hq = 0;
            prod = hq * longint'(cfg_gain);
            prod = (prod + (longint'(1) << 23)) >> 24;
            r.terrain_height = (prod > 64'hFFFF) ? 16'hFFFF : prod[15:0];
            r.inside_grid    = 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] aim_coord(longint g);
        longint q;
        if (cfg_ics == 16'd0)
            return 16'($urandom);
        q = g / longint'(cfg_ics);
        if (q > 32767)
            q = 32767;
        return 16'(q);
    endfunction

    task automatic flag_mismatch(string msg);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic send_item(item_t it);
        int unsigned gap;
        gap = tx_idle_en ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        if (it.mode == MODE_LOAD)
        begin
            height_mirror[it.sample_index]  = it.sample_value;
            sample_written[it.sample_index] = 1'b1;
        end
        else
            height_expected.push_back(predict_height(it.query_x, it.query_z));
    endtask

    task automatic send_load(logic [15:0] idx, logic [7:0] val);
        item_t it;
        it.mode         = MODE_LOAD;
        it.sample_index = idx;
        it.sample_value = val;
        it.query_x      = 16'($urandom);
        it.query_z      = 16'($urandom);
        send_item(it);
    endtask

    task automatic send_query(logic signed [15:0] qx, logic signed [15:0] qz);
        item_t  it;
        int     cx;
        int     cz;
        int     w;
        longint fx;
        longint fz;
        int     corner [4];
        if (locate_cell(qx, qz, cx, cz, fx, fz))
        begin
            w         = eff_size(cfg_width, MAX_GRID_WIDTH);
            corner[0] = cx + cz * w;
            corner[1] = corner[0] + 1;
            corner[2] = corner[0] + w;
            corner[3] = corner[2] + 1;
            foreach (corner[k])
                if (!sample_written[corner[k]])
                    send_load(16'(corner[k]), 8'($urandom));
        end
        it.mode         = MODE_QUERY;
        it.sample_index = 16'($urandom);
        it.sample_value = 8'($urandom);
        it.query_x      = qx;
        it.query_z      = qz;
        send_item(it);
    endtask

    task automatic send_aimed_query();
        longint gx;
        longint gz;
        gx = longint'($urandom_range(0, eff_size(cfg_width, MAX_GRID_WIDTH))) * UNIT_Q16
           + longint'($urandom_range(0, 65535));
        gz = longint'($urandom_range(0, eff_size(cfg_depth, MAX_GRID_DEPTH))) * UNIT_Q16
           + longint'($urandom_range(0, 65535));
        send_query(aim_coord(gx), aim_coord(gz));
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (height_expected.size() != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic random_item();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            send_aimed_query();
        else if (pick < 75)
            send_query(16'($urandom), 16'($urandom));
        else if (pick < 93)
            send_load(16'($urandom), 8'($urandom));
        else if (pick < 98)
            send_load(16'($urandom), pick[0] ? 8'hFF : 8'h00);
        else
            wait_idle();
    endtask

    task automatic check_register(cfg_reg_t sel);
        logic [PDATA_W-1:0] want;
        case (sel)
            REG_GRID_WIDTH:        want = PDATA_W'(cfg_width);
            REG_GRID_DEPTH:        want = PDATA_W'(cfg_depth);
            REG_INVERSE_CELL_SIZE: want = PDATA_W'(cfg_ics);
            default:               want = PDATA_W'(cfg_gain);
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
            flag_mismatch($sformatf("register %s: expected %0d, got %0d",
                                    sel.name(), want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_register(cfg_reg_t sel, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (sel)
            REG_GRID_WIDTH:        cfg_width = value[8:0];
            REG_GRID_DEPTH:        cfg_depth = value[8:0];
            REG_INVERSE_CELL_SIZE: cfg_ics   = value[15:0];
            default:               cfg_gain  = value[15:0];
        endcase
        @(posedge clk);
        check_register(sel);
    endtask

    task automatic apply_settings(int w, int d, int ics, int gain);
        write_register(REG_GRID_WIDTH, w);
        write_register(REG_GRID_DEPTH, d);
        write_register(REG_INVERSE_CELL_SIZE, ics);
        write_register(REG_HEIGHT_GAIN, gain);
    endtask

    task automatic test_reset_values();
        check_register(REG_GRID_WIDTH);
        check_register(REG_GRID_DEPTH);
        check_register(REG_INVERSE_CELL_SIZE);
        check_register(REG_HEIGHT_GAIN);
    endtask

    task automatic test_default_queries();
        send_load(16'd0, 8'h00);
        send_load(16'd1, 8'hFF);
        send_load(16'd256, 8'hFF);
        send_load(16'd257, 8'h00);
        send_load(16'hFFFF, 8'hFF);
        send_query(16'h0000, 16'h0000);
        send_query(16'h0080, 16'h0080);
        send_query(16'h0080, 16'h007F);
        send_query(16'h00FF, 16'h00FF);
        send_query(16'hFFFF, 16'h0000);
        send_query(16'h0000, 16'h8000);
        send_query(16'h7FFF, 16'h7FFF);
        send_query(16'h0100, 16'h0100);
    endtask

    task automatic test_grid_edges();
        wait_idle();
        apply_settings(4, 3, 256, 65535);
        send_query(16'h02FF, 16'h01FF);
        send_query(16'h0300, 16'h0000);
        send_query(16'h0000, 16'h0200);
        wait_idle();
        apply_settings(4, 3, 256, 0);
        send_query(16'h0140, 16'h0040);
        wait_idle();
        apply_settings(511, 300, 65535, 6554);
        send_query(16'h00FF, 16'h00FF);
        send_query(16'h0100, 16'h0000);
        send_query(16'h0000, 16'h0100);
        wait_idle();
        apply_settings(256, 256, 1, 6554);
        send_query(16'h7FFF, 16'h7FFF);
        send_query(16'h8000, 16'h0000);
        wait_idle();
        apply_settings(256, 256, 0, 6554);
        send_query(16'h1234, 16'h8000);
    endtask

    task automatic test_small_grid();
        wait_idle();
        apply_settings(0, 256, 256, 6554);
        send_query(16'h0000, 16'h0000);
        send_query(16'h0100, 16'h0100);
        wait_idle();
        apply_settings(256, 1, 256, 6554);
        send_query(16'h0000, 16'h0000);
        wait_idle();
        apply_settings(1, 2, 256, 6554);
        send_query(16'h0080, 16'h0000);
        wait_idle();
        apply_settings(2, 2, 256, 6554);
        send_query(16'h0080, 16'h0080);
        send_query(16'h0100, 16'h0000);
    endtask

    task automatic test_backpressure();
        wait_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_len   = 300;
        -> hold_go;
        repeat (40) send_aimed_query();
        wait_idle();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (20) random_item();
        wait_idle();
        repeat (20) random_item();
    endtask

    task automatic test_random_traffic();
        int unsigned r;
        int          w;
        int          d;
        int          ics;
        int          gain;
        for (int phase = 0; phase < 5; phase++)
        begin
            r = $urandom_range(0, 9);
            w = (r == 0) ? $urandom_range(0, 1) : (r == 1) ? $urandom_range(257, 511) :
                (r == 2) ? $urandom_range(17, 256) : $urandom_range(2, 16);
            r = $urandom_range(0, 9);
            d = (r == 0) ? $urandom_range(0, 1) : (r == 1) ? $urandom_range(257, 511) :
                (r == 2) ? $urandom_range(17, 256) : $urandom_range(2, 16);
            r = $urandom_range(0, 9);
            ics = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(1, 65535);
            r = $urandom_range(0, 9);
            gain = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 65535);
            wait_idle();
            apply_settings(w, d, ics, gain);
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            repeat (60) random_item();
        end
    endtask

    initial
    begin
        hold_off <= 1'b0;
        forever
        begin
            @(hold_go);
            hold_off <= 1'b1;
            repeat (hold_len) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    initial
    begin
        int unsigned rx_wait;
        result_t     want;
        rx_wait = 0;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && !result_stall)
            begin
                if (height_expected.size() == 0)
                    flag_mismatch($sformatf("unexpected transaction: height %0d inside %0b",
                                            result.terrain_height, result.inside_grid));
                else
                begin
                    want = height_expected.pop_front();
                    if (result.terrain_height !== want.terrain_height)
                        flag_mismatch($sformatf("terrain_height: expected %0d, got %0d",
                                                want.terrain_height, result.terrain_height));
                    if (result.inside_grid !== want.inside_grid)
                        flag_mismatch($sformatf("inside_grid: expected %0b, got %0b",
                                                want.inside_grid, result.inside_grid));
                end
                rx_wait = rx_idle_en ? $urandom_range(0, 15) : 0;
            end
            else if (rx_wait > 0)
                rx_wait--;
            result_stall <= hold_off || (rx_wait > 0);
        end
    end

    initial
    begin
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_default_queries();
        test_grid_edges();
        test_small_grid();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (err_count == 0 && height_expected.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
design/hmq_pkg.sv
design/hmq_ram.sv
design/heightmap_height_query_top.sv
design/hmq_checker.sv
tb/sv/heightmap_height_query_top_tb.sv
